// ===== src/bdb_pkg.sv =====
// ----------------------------------------------------------------------------
// bdb_pkg
// Shared types, constants and codes for the B-spline de Boor evaluator.
// ----------------------------------------------------------------------------
package bdb_pkg;

    localparam int MAX_POINTS = 64;
    localparam int MAX_DEGREE = 7;
    localparam int FRAC_BITS  = 16;
    localparam int KNOT_DEPTH = MAX_POINTS + MAX_DEGREE + 1;

    localparam logic [16:0] ONE_FX = 17'h10000;

    localparam logic [2:0] ACT_BUILD  = 3'd0;
    localparam logic [2:0] ACT_APPEND = 3'd1;
    localparam logic [2:0] ACT_SET    = 3'd2;
    localparam logic [2:0] ACT_KNOT   = 3'd3;
    localparam logic [2:0] ACT_EVAL   = 3'd4;
    localparam logic [2:0] ACT_INSERT = 3'd5;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_RANGE   = 3'd2;
    localparam logic [2:0] ST_OUTSIDE = 3'd3;
    localparam logic [2:0] ST_BAD_CFG = 3'd4;

    localparam logic [1:0] CFG_DEGREE = 2'd0;
    localparam logic [1:0] CFG_TARGET = 2'd1;

    typedef struct packed {
        logic [2:0]         action;
        logic [6:0]         item_index;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [23:0]        knot_value;
        logic [23:0]        eval_position;
    } item_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic [2:0]         status;
        logic [6:0]         points_held;
        logic [6:0]         knots_held;
        logic               complete;
    } result_t;

    typedef enum logic [1:0] {KW_BUILD, KW_IN, KW_NK, KW_RD} kw_sel_t;
    typedef enum logic [1:0] {PW_IN, PW_RD, PW_BLEND} pw_sel_t;
    typedef enum logic {SW_PT, SW_BLEND} sw_sel_t;
    typedef enum logic [1:0] {MUL_XA, MUL_XB, MUL_YA, MUL_YB} mul_sel_t;

    typedef struct packed {
        logic       in_ld;
        logic [6:0] k_raddr;
        logic       k_we;
        logic [6:0] k_waddr;
        kw_sel_t    k_wsel;
        logic [5:0] p_raddr;
        logic       p_we;
        logic [5:0] p_waddr;
        pw_sel_t    p_wsel;
        logic [2:0] s_raddr;
        logic       s_we;
        logic [2:0] s_waddr;
        sw_sel_t    s_wsel;
        logic       t0_ld;
        logic       nk_ld;
        logic       div_start;
        logic       a_ld;
        logic       b_ld;
        logic       op_src_pt;
        mul_sel_t   mul_sel;
        logic       acc_ld;
        logic       add_x;
        logic       add_y;
        logic       pc_inc;
        logic       pc_clr;
        logic       kc_inc;
        logic       kc_build;
        logic       out_ld;
        logic [2:0] out_status;
        logic       out_res;
    } cmd_t;

    typedef struct packed {
        logic [2:0] action;
        logic [6:0] idx;
        logic [2:0] degree;
        logic [6:0] target;
        logic [6:0] pc;
        logic [6:0] kc;
        logic       kgt;
        logic       div_busy;
        logic       out_free;
    } stat_t;

endpackage

// ===== src/bspline_de_boor_evaluator.sv =====
// ----------------------------------------------------------------------------
// bspline_de_boor_evaluator
// 2-D B-spline store with de Boor evaluation and midpoint knot insertion.
// ----------------------------------------------------------------------------
// Items arrive on item/item_valid; a transfer happens when item_stall is low.
// Each item gives exactly one result on result/result_valid, held until a
// cycle with result_stall low. One item is worked on at a time; the next is
// taken once the current result is in the output register, so a waiting
// result does not hold off the next item.
// Work per item: point and knot writes are done at dispatch; uniform build
// writes knots 0 to n+d; evaluation searches the knots, loads d+1 points and
// blends d(d+1)/2 triangle nodes; insertion shifts the points and knots up
// and blends d nodes. A node uses the weight divider (16 quotient bits)
// and the single shared 18x32 multiplier (four products per blend).
// cfg_index/cfg_data write curve_degree (0) and point_target (1); cfg_ready
// is always high. Reset clears counts and restores degree 3, target 4; store
// contents are undefined until written.
// ----------------------------------------------------------------------------
module bspline_de_boor_evaluator (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  bdb_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output bdb_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [6:0]       cfg_data
);

    bdb_pkg::cmd_t  cmd;
    bdb_pkg::stat_t st;

    bdb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .st         (st),
        .cmd        (cmd)
    );

    bdb_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .item         (item),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

endmodule

// ===== src/bdb_div.sv =====
// ----------------------------------------------------------------------------
// bdb_div
// Blend weight unit: clamped fixed-point ratio num/den, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module bdb_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [24:0] num,
    input  logic signed [24:0] den,
    output logic               busy,
    output logic [16:0]        alpha
);

    logic [23:0] rem_reg, rem_next;
    logic [23:0] den_reg, den_next;
    logic [15:0] q_reg, q_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [16:0] alpha_reg, alpha_next;

    logic [24:0] num_abs, den_abs, rem2, diff;

    always_comb
    begin
        num_abs    = num[24] ? -num : num;
        den_abs    = den[24] ? -den : den;
        rem2       = {rem_reg, 1'b0};
        diff       = rem2 - {1'b0, den_reg};
        rem_next   = rem_reg;
        den_next   = den_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        alpha_next = alpha_reg;
        if (start)
        begin
            rem_next = num_abs[23:0];
            den_next = den_abs[23:0];
            q_next   = '0;
            cnt_next = 5'd16;
            if (den == '0 || num == '0 || num[24] != den[24])
            begin
                alpha_next = '0;
                busy_next  = 1'b0;
            end
            else if (num_abs >= den_abs)
            begin
                alpha_next = bdb_pkg::ONE_FX;
                busy_next  = 1'b0;
            end
            else
            begin
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (!diff[24])
            begin
                rem_next = diff[23:0];
                q_next   = {q_reg[14:0], 1'b1};
            end
            else
            begin
                rem_next = rem2[23:0];
                q_next   = {q_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next  = 1'b0;
                alpha_next = {1'b0, q_next};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        q_reg     <= q_next;
        alpha_reg <= alpha_next;
    end

    assign busy  = busy_reg;
    assign alpha = alpha_reg;

endmodule

// ===== src/bdb_datapath.sv =====
// ----------------------------------------------------------------------------
// bdb_datapath
// Knot, point and triangle stores, counts, configuration, blend and result.
// ----------------------------------------------------------------------------
module bdb_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  bdb_pkg::cmd_t    cmd,
    output bdb_pkg::stat_t   st,
    input  bdb_pkg::item_t   item,
    output bdb_pkg::result_t result,
    output logic             result_valid,
    input  logic             result_stall,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [6:0]       cfg_data
);

    logic [23:0] knot_mem [bdb_pkg::KNOT_DEPTH];
    logic [31:0] px_mem [bdb_pkg::MAX_POINTS];
    logic [31:0] py_mem [bdb_pkg::MAX_POINTS];
    logic [63:0] scr_mem [bdb_pkg::MAX_DEGREE + 1];

    bdb_pkg::item_t   item_reg;
    bdb_pkg::result_t out_reg;
    logic        out_valid_reg;
    logic [2:0]  degree_reg;
    logic [6:0]  target_reg;
    logic [6:0]  pc_reg, kc_reg;
    logic [23:0] k_rdata_reg, t0_reg, param_reg;
    logic [31:0] px_rdata_reg, py_rdata_reg;
    logic [63:0] s_rdata_reg;
    logic signed [31:0] a_x_reg, a_y_reg, b_x_reg, b_y_reg;
    logic signed [31:0] res_x_reg, res_y_reg;
    logic signed [49:0] prod_reg, acc_reg;

    logic [23:0] k_wdata, build_val;
    logic [6:0]  build_v;
    logic [31:0] px_wdata, py_wdata;
    logic [63:0] s_wdata;
    logic [24:0] nk_sum;
    logic signed [24:0] div_num, div_den;
    logic [16:0] alpha, factor;
    logic signed [31:0] mul_d, op_x, op_y;
    logic signed [17:0] mul_f;
    logic signed [49:0] prod;
    logic signed [50:0] sum;
    logic        div_busy;

    bdb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .alpha (alpha)
    );

    assign div_num = $signed({1'b0, param_reg}) - $signed({1'b0, t0_reg});
    assign div_den = $signed({1'b0, k_rdata_reg}) - $signed({1'b0, t0_reg});
    assign nk_sum  = {1'b0, t0_reg} + {1'b0, k_rdata_reg};

    always_comb
    begin
        if ({1'b0, cmd.k_waddr} <= {5'd0, degree_reg} + 8'd0 && cmd.k_waddr[6:3] == 4'd0
            && cmd.k_waddr[2:0] <= degree_reg)
            build_v = '0;
        else if (cmd.k_waddr <= {4'd0, degree_reg})
            build_v = '0;
        else if (cmd.k_waddr < target_reg)
            build_v = cmd.k_waddr - {4'd0, degree_reg};
        else
            build_v = target_reg - {4'd0, degree_reg};
        build_val = {1'b0, build_v, 16'd0};
    end

    always_comb
    begin
        unique case (cmd.k_wsel)
            bdb_pkg::KW_BUILD: k_wdata = build_val;
            bdb_pkg::KW_IN:    k_wdata = item_reg.knot_value;
            bdb_pkg::KW_NK:    k_wdata = param_reg;
            bdb_pkg::KW_RD:    k_wdata = k_rdata_reg;
            default:           k_wdata = k_rdata_reg;
        endcase
        unique case (cmd.p_wsel)
            bdb_pkg::PW_IN:
            begin
                px_wdata = item_reg.point_x;
                py_wdata = item_reg.point_y;
            end
            bdb_pkg::PW_RD:
            begin
                px_wdata = px_rdata_reg;
                py_wdata = py_rdata_reg;
            end
            default:
            begin
                px_wdata = res_x_reg;
                py_wdata = res_y_reg;
            end
        endcase
        unique case (cmd.s_wsel)
            bdb_pkg::SW_PT: s_wdata = {px_rdata_reg, py_rdata_reg};
            default:        s_wdata = {res_x_reg, res_y_reg};
        endcase
    end

    always_comb
    begin
        op_x = cmd.op_src_pt ? $signed(px_rdata_reg) : $signed(s_rdata_reg[63:32]);
        op_y = cmd.op_src_pt ? $signed(py_rdata_reg) : $signed(s_rdata_reg[31:0]);
        unique case (cmd.mul_sel)
            bdb_pkg::MUL_XA:
            begin
                factor = bdb_pkg::ONE_FX - alpha;
                mul_d  = a_x_reg;
            end
            bdb_pkg::MUL_XB:
            begin
                factor = alpha;
                mul_d  = b_x_reg;
            end
            bdb_pkg::MUL_YA:
            begin
                factor = bdb_pkg::ONE_FX - alpha;
                mul_d  = a_y_reg;
            end
            default:
            begin
                factor = alpha;
                mul_d  = b_y_reg;
            end
        endcase
        mul_f = $signed({1'b0, factor});
        prod  = mul_f * mul_d;
        sum   = {acc_reg[49], acc_reg} + {prod_reg[49], prod_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.k_we)
            knot_mem[cmd.k_waddr] <= k_wdata;
        k_rdata_reg <= knot_mem[cmd.k_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.p_we)
        begin
            px_mem[cmd.p_waddr] <= px_wdata;
            py_mem[cmd.p_waddr] <= py_wdata;
        end
        px_rdata_reg <= px_mem[cmd.p_raddr];
        py_rdata_reg <= py_mem[cmd.p_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.s_we)
            scr_mem[cmd.s_waddr] <= s_wdata;
        s_rdata_reg <= scr_mem[cmd.s_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_ld)
            item_reg <= item;
        if (cmd.in_ld)
            param_reg <= item.eval_position;
        else if (cmd.nk_ld)
            param_reg <= nk_sum[24:1];
        if (cmd.t0_ld)
            t0_reg <= k_rdata_reg;
        if (cmd.a_ld)
        begin
            a_x_reg <= op_x;
            a_y_reg <= op_y;
        end
        if (cmd.b_ld)
        begin
            b_x_reg <= op_x;
            b_y_reg <= op_y;
        end
        prod_reg <= prod;
        if (cmd.acc_ld)
            acc_reg <= prod_reg;
        if (cmd.add_x)
            res_x_reg <= sum[47:16];
        if (cmd.add_y)
            res_y_reg <= sum[47:16];
        if (cmd.out_ld)
        begin
            out_reg.out_x       <= cmd.out_res ? res_x_reg : 32'sd0;
            out_reg.out_y       <= cmd.out_res ? res_y_reg : 32'sd0;
            out_reg.status      <= cmd.out_status;
            out_reg.points_held <= pc_reg;
            out_reg.knots_held  <= kc_reg;
            out_reg.complete    <= (pc_reg >= target_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg    <= 3'd3;
            target_reg    <= 7'd4;
            pc_reg        <= '0;
            kc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == bdb_pkg::CFG_DEGREE)
                degree_reg <= cfg_data[2:0];
            if (cfg_valid && cfg_index == bdb_pkg::CFG_TARGET)
                target_reg <= cfg_data;
            if (cmd.pc_clr)
                pc_reg <= '0;
            else if (cmd.pc_inc)
                pc_reg <= pc_reg + 7'd1;
            if (cmd.kc_build)
                kc_reg <= target_reg + {4'd0, degree_reg} + 7'd1;
            else if (cmd.kc_inc)
                kc_reg <= kc_reg + 7'd1;
            if (cmd.out_ld)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign cfg_ready    = 1'b1;
    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    assign st.action   = item_reg.action;
    assign st.idx      = item_reg.item_index;
    assign st.degree   = degree_reg;
    assign st.target   = target_reg;
    assign st.pc       = pc_reg;
    assign st.kc       = kc_reg;
    assign st.kgt      = k_rdata_reg > param_reg;
    assign st.div_busy = div_busy;
    assign st.out_free = !out_valid_reg || !result_stall;

endmodule

// ===== src/bdb_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdb_ctrl
// Sequencer: checks, store walks, de Boor triangle and Boehm insertion steps.
// ----------------------------------------------------------------------------
module bdb_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_stall,
    input  bdb_pkg::stat_t st,
    output bdb_pkg::cmd_t  cmd
);

    typedef enum logic [26:0] {
        S_IDLE     = 27'd1 << 0,
        S_DISP     = 27'd1 << 1,
        S_BUILD    = 27'd1 << 2,
        S_SRCH_RD  = 27'd1 << 3,
        S_SRCH_CMP = 27'd1 << 4,
        S_LD_RD    = 27'd1 << 5,
        S_LD_WR    = 27'd1 << 6,
        S_T0       = 27'd1 << 7,
        S_T1       = 27'd1 << 8,
        S_DIV      = 27'd1 << 9,
        S_OPA      = 27'd1 << 10,
        S_OPB      = 27'd1 << 11,
        S_DIVW     = 27'd1 << 12,
        S_BL1      = 27'd1 << 13,
        S_BL2      = 27'd1 << 14,
        S_BL3      = 27'd1 << 15,
        S_BL4      = 27'd1 << 16,
        S_BL5      = 27'd1 << 17,
        S_WB       = 27'd1 << 18,
        S_INS_T0   = 27'd1 << 19,
        S_INS_T1   = 27'd1 << 20,
        S_PS_RD    = 27'd1 << 21,
        S_PS_WR    = 27'd1 << 22,
        S_KS_RD    = 27'd1 << 23,
        S_KS_WR    = 27'd1 << 24,
        S_KNK      = 27'd1 << 25,
        S_FIN      = 27'd1 << 26
    } state_t;

    state_t     state_reg, state_next;
    logic [6:0] i_reg, i_next;
    logic [6:0] j_reg, j_next;
    logic [2:0] r_reg, r_next;
    logic [2:0] s_reg, s_next;
    logic [2:0] st_reg, st_next;
    logic       res_reg, res_next;

    logic [7:0] d8, i8, j8, s8, r8, h8, pc8, kc8, n8, jj8, t0a8, t1a8;
    logic       is_eval;

    always_comb
    begin
        d8      = {5'd0, st.degree};
        i8      = {1'b0, i_reg};
        j8      = {1'b0, j_reg};
        s8      = {5'd0, s_reg};
        r8      = {5'd0, r_reg};
        h8      = {1'b0, st.idx};
        pc8     = {1'b0, st.pc};
        kc8     = {1'b0, st.kc};
        n8      = {1'b0, st.target};
        jj8     = i8 - 8'd1;
        is_eval = (st.action == bdb_pkg::ACT_EVAL);
        t0a8    = is_eval ? j8 - d8 + s8 : i8;
        t1a8    = is_eval ? j8 + s8 + 8'd1 - r8 : i8 + d8;

        cmd        = '0;
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        r_next     = r_reg;
        s_next     = s_reg;
        st_next    = st_reg;
        res_next   = res_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.in_ld  = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                res_next   = 1'b0;
                st_next    = bdb_pkg::ST_OK;
                state_next = S_FIN;
                unique case (st.action)
                    bdb_pkg::ACT_BUILD:
                    begin
                        if (st.degree == 3'd0 || n8 < 8'd2
                            || n8 > 8'(bdb_pkg::MAX_POINTS) || n8 < d8 + 8'd1)
                            st_next = bdb_pkg::ST_BAD_CFG;
                        else
                        begin
                            i_next     = '0;
                            state_next = S_BUILD;
                        end
                    end
                    bdb_pkg::ACT_APPEND:
                    begin
                        if (st.pc >= st.target || pc8 >= 8'(bdb_pkg::MAX_POINTS))
                            st_next = bdb_pkg::ST_FULL;
                        else
                        begin
                            cmd.p_we    = 1'b1;
                            cmd.p_waddr = st.pc[5:0];
                            cmd.p_wsel  = bdb_pkg::PW_IN;
                            cmd.pc_inc  = 1'b1;
                        end
                    end
                    bdb_pkg::ACT_SET:
                    begin
                        if (st.idx >= st.pc)
                            st_next = bdb_pkg::ST_RANGE;
                        else
                        begin
                            cmd.p_we    = 1'b1;
                            cmd.p_waddr = st.idx[5:0];
                            cmd.p_wsel  = bdb_pkg::PW_IN;
                        end
                    end
                    bdb_pkg::ACT_KNOT:
                    begin
                        cmd.k_waddr = st.idx;
                        cmd.k_wsel  = bdb_pkg::KW_IN;
                        if (st.idx < st.kc)
                            cmd.k_we = 1'b1;
                        else if (st.idx == st.kc && kc8 < 8'(bdb_pkg::KNOT_DEPTH))
                        begin
                            cmd.k_we   = 1'b1;
                            cmd.kc_inc = 1'b1;
                        end
                        else
                            st_next = bdb_pkg::ST_RANGE;
                    end
                    bdb_pkg::ACT_EVAL:
                    begin
                        if (st.degree == 3'd0)
                            st_next = bdb_pkg::ST_BAD_CFG;
                        else if (kc8 <= 8'd1)
                            st_next = bdb_pkg::ST_OUTSIDE;
                        else
                        begin
                            i_next     = 7'd1;
                            state_next = S_SRCH_RD;
                        end
                    end
                    bdb_pkg::ACT_INSERT:
                    begin
                        if (st.degree == 3'd0)
                            st_next = bdb_pkg::ST_BAD_CFG;
                        else if (h8 < d8 || h8 + 8'd1 >= pc8 || h8 + d8 >= kc8)
                            st_next = bdb_pkg::ST_RANGE;
                        else if (pc8 >= 8'(bdb_pkg::MAX_POINTS)
                                 || kc8 >= 8'(bdb_pkg::KNOT_DEPTH))
                            st_next = bdb_pkg::ST_FULL;
                        else
                        begin
                            cmd.k_raddr = st.idx;
                            state_next  = S_INS_T0;
                        end
                    end
                    default:
                        st_next = bdb_pkg::ST_OK;
                endcase
            end
            S_BUILD:
            begin
                cmd.k_we    = 1'b1;
                cmd.k_waddr = i_reg;
                cmd.k_wsel  = bdb_pkg::KW_BUILD;
                if (i8 == n8 + d8)
                begin
                    cmd.kc_build = 1'b1;
                    cmd.pc_clr   = 1'b1;
                    state_next   = S_FIN;
                end
                else
                    i_next = i_reg + 7'd1;
            end
            S_SRCH_RD:
            begin
                cmd.k_raddr = i_reg;
                state_next  = S_SRCH_CMP;
            end
            S_SRCH_CMP:
            begin
                if (st.kgt)
                begin
                    j_next = jj8[6:0];
                    if (jj8 < d8 || jj8 + d8 >= kc8)
                    begin
                        st_next    = bdb_pkg::ST_OUTSIDE;
                        state_next = S_FIN;
                    end
                    else if (jj8 >= pc8)
                    begin
                        st_next    = bdb_pkg::ST_RANGE;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        s_next     = '0;
                        state_next = S_LD_RD;
                    end
                end
                else if (i8 + 8'd1 >= kc8)
                begin
                    st_next    = bdb_pkg::ST_OUTSIDE;
                    state_next = S_FIN;
                end
                else
                begin
                    i_next     = i_reg + 7'd1;
                    state_next = S_SRCH_RD;
                end
            end
            S_LD_RD:
            begin
                cmd.p_raddr = t0a8[5:0];
                state_next  = S_LD_WR;
            end
            S_LD_WR:
            begin
                cmd.s_we    = 1'b1;
                cmd.s_waddr = s_reg;
                cmd.s_wsel  = bdb_pkg::SW_PT;
                if (s_reg == st.degree)
                begin
                    r_next     = 3'd1;
                    s_next     = st.degree;
                    state_next = S_T0;
                end
                else
                begin
                    s_next     = s_reg + 3'd1;
                    state_next = S_LD_RD;
                end
            end
            S_T0:
            begin
                cmd.k_raddr = t0a8[6:0];
                state_next  = S_T1;
            end
            S_T1:
            begin
                cmd.t0_ld   = 1'b1;
                cmd.k_raddr = t1a8[6:0];
                state_next  = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.s_raddr   = s_reg - 3'd1;
                cmd.p_raddr   = i_reg[5:0] - 6'd1;
                state_next    = S_OPA;
            end
            S_OPA:
            begin
                cmd.a_ld      = 1'b1;
                cmd.op_src_pt = !is_eval;
                cmd.s_raddr   = s_reg;
                cmd.p_raddr   = i_reg[5:0];
                state_next    = S_OPB;
            end
            S_OPB:
            begin
                cmd.b_ld      = 1'b1;
                cmd.op_src_pt = !is_eval;
                state_next    = S_DIVW;
            end
            S_DIVW:
            begin
                if (!st.div_busy)
                    state_next = S_BL1;
            end
            S_BL1:
            begin
                cmd.mul_sel = bdb_pkg::MUL_XA;
                state_next  = S_BL2;
            end
            S_BL2:
            begin
                cmd.mul_sel = bdb_pkg::MUL_XB;
                cmd.acc_ld  = 1'b1;
                state_next  = S_BL3;
            end
            S_BL3:
            begin
                cmd.mul_sel = bdb_pkg::MUL_YA;
                cmd.add_x   = 1'b1;
                state_next  = S_BL4;
            end
            S_BL4:
            begin
                cmd.mul_sel = bdb_pkg::MUL_YB;
                cmd.acc_ld  = 1'b1;
                state_next  = S_BL5;
            end
            S_BL5:
            begin
                cmd.add_y  = 1'b1;
                state_next = S_WB;
            end
            S_WB:
            begin
                if (is_eval)
                begin
                    cmd.s_we    = 1'b1;
                    cmd.s_waddr = s_reg;
                    cmd.s_wsel  = bdb_pkg::SW_BLEND;
                    if (s_reg == r_reg)
                    begin
                        if (r_reg == st.degree)
                        begin
                            res_next   = 1'b1;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            r_next     = r_reg + 3'd1;
                            s_next     = st.degree;
                            state_next = S_T0;
                        end
                    end
                    else
                    begin
                        s_next     = s_reg - 3'd1;
                        state_next = S_T0;
                    end
                end
                else
                begin
                    cmd.p_we    = 1'b1;
                    cmd.p_waddr = i_reg[5:0];
                    cmd.p_wsel  = bdb_pkg::PW_BLEND;
                    if (i8 == h8 - d8 + 8'd1)
                    begin
                        i_next     = st.kc;
                        state_next = S_KS_RD;
                    end
                    else
                    begin
                        i_next     = i_reg - 7'd1;
                        state_next = S_T0;
                    end
                end
            end
            S_INS_T0:
            begin
                cmd.t0_ld   = 1'b1;
                cmd.k_raddr = st.idx + 7'd1;
                state_next  = S_INS_T1;
            end
            S_INS_T1:
            begin
                cmd.nk_ld  = 1'b1;
                i_next     = st.pc;
                state_next = S_PS_RD;
            end
            S_PS_RD:
            begin
                cmd.p_raddr = i_reg[5:0] - 6'd1;
                state_next  = S_PS_WR;
            end
            S_PS_WR:
            begin
                cmd.p_we    = 1'b1;
                cmd.p_waddr = i_reg[5:0];
                cmd.p_wsel  = bdb_pkg::PW_RD;
                if (i8 == h8 + 8'd1)
                begin
                    i_next     = st.idx;
                    state_next = S_T0;
                end
                else
                begin
                    i_next     = i_reg - 7'd1;
                    state_next = S_PS_RD;
                end
            end
            S_KS_RD:
            begin
                cmd.k_raddr = i_reg - 7'd1;
                state_next  = S_KS_WR;
            end
            S_KS_WR:
            begin
                cmd.k_we    = 1'b1;
                cmd.k_waddr = i_reg;
                cmd.k_wsel  = bdb_pkg::KW_RD;
                if (i8 == h8 + 8'd2)
                    state_next = S_KNK;
                else
                begin
                    i_next     = i_reg - 7'd1;
                    state_next = S_KS_RD;
                end
            end
            S_KNK:
            begin
                cmd.k_we    = 1'b1;
                cmd.k_waddr = st.idx + 7'd1;
                cmd.k_wsel  = bdb_pkg::KW_NK;
                cmd.pc_inc  = 1'b1;
                cmd.kc_inc  = 1'b1;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                if (st.out_free)
                begin
                    cmd.out_ld     = 1'b1;
                    cmd.out_status = st_reg;
                    cmd.out_res    = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            r_reg     <= '0;
            s_reg     <= '0;
            st_reg    <= '0;
            res_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            r_reg     <= r_next;
            s_reg     <= s_next;
            st_reg    <= st_next;
            res_reg   <= res_next;
        end
    end

    assign item_stall = (state_reg != S_IDLE);

endmodule
